@@ design/bcd_clock_with_seven_segment_out_top_defines.svh @@
// ----------------------------------------------------------------------------
// BCD clock assertion macros
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BCD_CLOCK_WITH_SEVEN_SEGMENT_OUT_TOP_DEFINES_SVH
`define BCD_CLOCK_WITH_SEVEN_SEGMENT_OUT_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BCDC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bcd clock assertion failed");
// next-cycle implication
`define BCDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bcd clock assertion failed");
`else
`define BCDC_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define BCDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ design/bcdclk_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcdclk_pkg
// Types, constants and digit helpers shared by the BCD clock modules.
// ----------------------------------------------------------------------------
package bcdclk_pkg;

    localparam logic [7:0]  EPS_RESET   = 8'd10;
    localparam logic [15:0] TIME_RESET  = 16'h5957;
    localparam logic [7:0]  SEG_BLANK   = 8'hFF;

    // switch bits 9..8
    typedef enum logic [1:0] {
        SEL_NONE = 2'b00,
        SEL_MIN  = 2'b01,
        SEL_SEC  = 2'b10,
        SEL_HOUR = 2'b11
    } t_sel;

    typedef struct packed {
        logic [7:0] sec_lo;
        logic [7:0] sec_hi;
        logic [7:0] min_lo;
        logic [7:0] min_hi;
        logic [7:0] hour_lo;
        logic [7:0] hour_hi;
    } t_segs;

    localparam logic [7:0] SEG_TABLE [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };

    // active-low pattern, dp off; digits above nine show dark
    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] pat;
        if (digit < 4'd10) begin
            pat = SEG_TABLE[digit];
        end else begin
            pat = SEG_BLANK;
        end
        return pat;
    endfunction

    // 0..63 -> {tens, ones}; the result is only used for values below 60
    function automatic logic [7:0] bin_to_bcd(input logic [5:0] v);
        logic [3:0] tens;
        logic [3:0] ones;
        if (v >= 6'd50) begin
            tens = 4'd5;
        end else if (v >= 6'd40) begin
            tens = 4'd4;
        end else if (v >= 6'd30) begin
            tens = 4'd3;
        end else if (v >= 6'd20) begin
            tens = 4'd2;
        end else if (v >= 6'd10) begin
            tens = 4'd1;
        end else begin
            tens = 4'd0;
        end
        ones = 4'(v - 6'(tens) * 6'd10);
        return {tens, ones};
    endfunction

endpackage

@@ design/bcdclk_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcdclk_core
// Time-of-day state, switch setting, second advance and segment encoding.
// ----------------------------------------------------------------------------
module bcdclk_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_button,
    input  logic [9:0]         i_switches,
    input  logic [7:0]         i_events_per_second,
    output logic               o_fire,
    output bcdclk_pkg::t_segs  o_segs
);
    import bcdclk_pkg::*;

    logic [7:0]  r_sub_cnt, n_sub_cnt;
    logic [15:0] r_min_sec, n_min_sec;
    logic [4:0]  r_hour,    n_hour;

    logic [7:0]  cnt_inc;
    logic [15:0] set_ms;
    logic [4:0]  set_hour;
    logic [7:0]  v_bcd;
    logic [5:0]  v;
    logic [15:0] adv_ms;
    logic [4:0]  adv_hour;
    logic [3:0]  d0, d1, d2, d3;
    logic        c0, c1, c2, c3;
    logic [3:0]  h_tens;
    logic [3:0]  h_ones;
    logic        match;

    assign cnt_inc = r_sub_cnt + 8'd1;
    assign match   = (cnt_inc == i_events_per_second);
    assign o_fire  = i_en && match;
    assign v       = i_switches[5:0];
    assign v_bcd   = bin_to_bcd(v);

    // apply a switch setting, out-of-range values leave the field alone
    always_comb begin
        set_ms   = r_min_sec;
        set_hour = r_hour;
        if (i_button) begin
            unique case (t_sel'(i_switches[9:8]))
                SEL_SEC: begin
                    if (v < 6'd60) set_ms = {r_min_sec[15:8], v_bcd};
                end
                SEL_MIN: begin
                    if (v < 6'd60) set_ms = {v_bcd, r_min_sec[7:0]};
                end
                SEL_HOUR: begin
                    if (v < 6'd24) set_hour = v[4:0];
                end
                SEL_NONE: ;
                default: ;
            endcase
        end
    end

    // BCD ripple increment with carries into hours
    always_comb begin
        c0 = (set_ms[3:0]   >= 4'd9);
        c1 = c0 && (set_ms[7:4]   >= 4'd5);
        c2 = c1 && (set_ms[11:8]  >= 4'd9);
        c3 = c2 && (set_ms[15:12] >= 4'd5);
        d0 = c0 ? 4'd0 : set_ms[3:0] + 4'd1;
        d1 = c1 ? 4'd0 : (c0 ? set_ms[7:4]   + 4'd1 : set_ms[7:4]);
        d2 = c2 ? 4'd0 : (c1 ? set_ms[11:8]  + 4'd1 : set_ms[11:8]);
        d3 = c3 ? 4'd0 : (c2 ? set_ms[15:12] + 4'd1 : set_ms[15:12]);
        adv_ms = {d3, d2, d1, d0};
        if (!c3) begin
            adv_hour = set_hour;
        end else if (set_hour >= 5'd23) begin
            adv_hour = 5'd0;
        end else begin
            adv_hour = set_hour + 5'd1;
        end
    end

    // hours split into decimal digits (hours stay below 32)
    always_comb begin
        if (set_hour >= 5'd30) begin
            h_tens = 4'd3;
        end else if (set_hour >= 5'd20) begin
            h_tens = 4'd2;
        end else if (set_hour >= 5'd10) begin
            h_tens = 4'd1;
        end else begin
            h_tens = 4'd0;
        end
        h_ones = 4'(set_hour - 5'(h_tens) * 5'd10);
    end

    always_comb begin
        o_segs.sec_lo  = seg_of(set_ms[3:0]);
        o_segs.sec_hi  = seg_of(set_ms[7:4]);
        o_segs.min_lo  = seg_of(set_ms[11:8]);
        o_segs.min_hi  = seg_of(set_ms[15:12]);
        o_segs.hour_lo = seg_of(h_ones);
        o_segs.hour_hi = seg_of(h_tens);
    end

    always_comb begin
        n_sub_cnt = r_sub_cnt;
        n_min_sec = r_min_sec;
        n_hour    = r_hour;
        if (i_en) begin
            if (match) begin
                n_sub_cnt = 8'd0;
                n_min_sec = adv_ms;
                n_hour    = adv_hour;
            end else begin
                n_sub_cnt = cnt_inc;
                n_min_sec = set_ms;
                n_hour    = set_hour;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub_cnt <= 8'd0;
            r_min_sec <= TIME_RESET;
            r_hour    <= 5'd0;
        end else begin
            r_sub_cnt <= n_sub_cnt;
            r_min_sec <= n_min_sec;
            r_hour    <= n_hour;
        end
    end

endmodule

@@ design/bcd_clock_with_seven_segment_out_top.sv @@
`timescale 1ns / 1ps
// Result path: a transaction that completes a second lands in the result
//   register that drives o_valid, or in the skid while the output stalls.
// Throughput: one event per cycle while the skid is empty; the time update
//   is a single pass of logic and result register plus skid absorb stalls.
// Reset (i_rst_n low, synchronous): time 00:59:57, counter 0, 10 events/s,
//   output stage empty.
// ----------------------------------------------------------------------------
// bcd_clock_with_seven_segment_out_top
// HH:MM:SS clock driven by timer events, with six seven-segment outputs.
// ----------------------------------------------------------------------------
`include "bcd_clock_with_seven_segment_out_top_defines.svh"

module bcd_clock_with_seven_segment_out_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_button,
    input  logic [9:0] i_switches,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_seg_sec_ones,
    output logic [7:0] o_seg_sec_tens,
    output logic [7:0] o_seg_min_ones,
    output logic [7:0] o_seg_min_tens,
    output logic [7:0] o_seg_hour_ones,
    output logic [7:0] o_seg_hour_tens
);
    import bcdclk_pkg::*;

    logic [7:0] r_eps;
    logic       in_acc;
    logic       fire;
    t_segs      new_segs;

    logic       r_out_valid, n_out_valid;
    logic       r_skid_valid, n_skid_valid;
    t_segs      r_out, n_out;
    t_segs      r_skid, n_skid;
    logic       out_take;

    assign o_ready  = !r_skid_valid;
    assign in_acc   = i_valid && o_ready;
    assign out_take = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    bcdclk_core u_core (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_en                (in_acc),
        .i_button            (i_button),
        .i_switches          (i_switches),
        .i_events_per_second (r_eps),
        .o_fire              (fire),
        .o_segs              (new_segs)
    );

    // result register with skid; skid only fills while the output is stalled
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = new_segs;
                n_out_valid = fire;
            end
        end else if (fire) begin
            n_skid       = new_segs;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid         = r_out_valid;
    assign o_seg_sec_ones  = r_out.sec_lo;
    assign o_seg_sec_tens  = r_out.sec_hi;
    assign o_seg_min_ones  = r_out.min_lo;
    assign o_seg_min_tens  = r_out.min_hi;
    assign o_seg_hour_ones = r_out.hour_lo;
    assign o_seg_hour_tens = r_out.hour_hi;

    // skid never holds a result ahead of an empty output register
    `BCDC_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    // a result produced while the output stalls lands in the skid
    `BCDC_ASSERT_NEXT(a_stall_to_skid, i_clk, i_rst_n, fire && r_out_valid && !i_ready, r_skid_valid)
    // a drained skid leaves the output register occupied
    `BCDC_ASSERT_NEXT(a_skid_drain, i_clk, i_rst_n, r_skid_valid && i_ready, r_out_valid && !r_skid_valid)

endmodule
